// ===== hdl/lpp_pkg.sv =====
// ----------------------------------------------------------------------------
// lpp_pkg
// Shared types, register map and datapath command codes for the lift
// position PID controller.
// ----------------------------------------------------------------------------
package lpp_pkg;

  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  // register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_GAIN_P_UP          = 3'd0;
  localparam logic [2:0] REG_GAIN_I_UP          = 3'd1;
  localparam logic [2:0] REG_GAIN_P_DOWN        = 3'd2;
  localparam logic [2:0] REG_GAIN_I_DOWN        = 3'd3;
  localparam logic [2:0] REG_INTEGRAL_DECAY     = 3'd4;
  localparam logic [2:0] REG_INTEGRAL_THRESHOLD = 3'd5;
  localparam logic [2:0] REG_TRAVEL_BOTTOM      = 3'd6;
  localparam logic [2:0] REG_TRAVEL_TOP         = 3'd7;

  // shared multiplier operand selection
  localparam logic [2:0] MUL_NONE   = 3'd0;
  localparam logic [2:0] MUL_DEC_LO = 3'd1;
  localparam logic [2:0] MUL_DEC_HI = 3'd2;
  localparam logic [2:0] MUL_ERR_DT = 3'd3;
  localparam logic [2:0] MUL_ERR_GP = 3'd4;
  localparam logic [2:0] MUL_SUM_LO = 3'd5;
  localparam logic [2:0] MUL_SUM_HI = 3'd6;

  typedef struct packed {
    logic [15:0]        gain_p_up;
    logic [15:0]        gain_i_up;
    logic [15:0]        gain_p_down;
    logic [15:0]        gain_i_down;
    logic [15:0]        integral_decay;
    logic signed [23:0] integral_threshold;
    logic signed [23:0] travel_bottom;
    logic signed [23:0] travel_top;
  } cfg_t;

  typedef struct packed {
    logic signed [23:0] position;
    logic signed [23:0] target;
    logic [7:0]         elapsed_ms;
    logic               manual_mode;
    logic signed [7:0]  manual_power;
    logic               frozen;
    logic               encoder_reset;
  } in_beat_t;

  typedef struct packed {
    logic signed [7:0]  drive_power;
    logic signed [23:0] target_out;
    logic               moving_down;
    logic               reset_request;
  } out_beat_t;

  typedef struct packed {
    logic       load;
    logic       prep;
    logic [2:0] mul_sel;
    logic       acc_load;
    logic       decay;
    logic       integ;
    logic       raw_clr;
    logic       raw_add;
    logic       raw_shift;
    logic       out_load;
  } cmd_t;

endpackage

// ===== hdl/lpp_in_if.sv =====
// ----------------------------------------------------------------------------
// lpp_in_if
// Input channel: one control tick per beat.
// ----------------------------------------------------------------------------
interface lpp_in_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] position;
  logic signed [23:0] target;
  logic [7:0]         elapsed_ms;
  logic               manual_mode;
  logic signed [7:0]  manual_power;
  logic               frozen;
  logic               encoder_reset;

  modport source (
    output valid, position, target, elapsed_ms, manual_mode, manual_power,
           frozen, encoder_reset,
    input  ready
  );
  modport sink (
    input  valid, position, target, elapsed_ms, manual_mode, manual_power,
           frozen, encoder_reset,
    output ready
  );
endinterface

// ===== hdl/lpp_out_if.sv =====
// ----------------------------------------------------------------------------
// lpp_out_if
// Result channel: one motor command per beat.
// ----------------------------------------------------------------------------
interface lpp_out_if;
  logic               valid;
  logic               ready;
  logic signed [7:0]  drive_power;
  logic signed [23:0] target_out;
  logic               moving_down;
  logic               reset_request;

  modport source (
    output valid, drive_power, target_out, moving_down, reset_request,
    input  ready
  );
  modport sink (
    input  valid, drive_power, target_out, moving_down, reset_request,
    output ready
  );
endinterface

// ===== hdl/lpp_regs.sv =====
// ----------------------------------------------------------------------------
// lpp_regs
// APB register file holding gains, decay, threshold and travel limits.
// ----------------------------------------------------------------------------
module lpp_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lpp_pkg::CFG_AW-1:0] paddr,
  input  logic [lpp_pkg::CFG_DW-1:0] pwdata,
  output logic [lpp_pkg::CFG_DW-1:0] prdata,
  output lpp_pkg::cfg_t              cfg
);

  lpp_pkg::cfg_t cfg_r;
  lpp_pkg::cfg_t cfg_nxt;
  logic          wr_en;
  logic [2:0]    idx;

  assign wr_en = psel & penable & pwrite;
  assign idx   = paddr[4:2];
  assign cfg   = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        lpp_pkg::REG_GAIN_P_UP:          cfg_nxt.gain_p_up          = pwdata[15:0];
        lpp_pkg::REG_GAIN_I_UP:          cfg_nxt.gain_i_up          = pwdata[15:0];
        lpp_pkg::REG_GAIN_P_DOWN:        cfg_nxt.gain_p_down        = pwdata[15:0];
        lpp_pkg::REG_GAIN_I_DOWN:        cfg_nxt.gain_i_down        = pwdata[15:0];
        lpp_pkg::REG_INTEGRAL_DECAY:     cfg_nxt.integral_decay     = pwdata[15:0];
        lpp_pkg::REG_INTEGRAL_THRESHOLD: cfg_nxt.integral_threshold = pwdata[23:0];
        lpp_pkg::REG_TRAVEL_BOTTOM:      cfg_nxt.travel_bottom      = pwdata[23:0];
        lpp_pkg::REG_TRAVEL_TOP:         cfg_nxt.travel_top         = pwdata[23:0];
        default:                         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_p_up          <= 16'd5374;
      cfg_r.gain_i_up          <= 16'd1114;
      cfg_r.gain_p_down        <= 16'd131;
      cfg_r.gain_i_down        <= 16'd328;
      cfg_r.integral_decay     <= 16'd57016;
      cfg_r.integral_threshold <= 24'sd500;
      cfg_r.travel_bottom      <= 24'sd0;
      cfg_r.travel_top         <= 24'sh7FFFFF;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    unique case (idx)
      lpp_pkg::REG_GAIN_P_UP:          prdata = {16'd0, cfg_r.gain_p_up};
      lpp_pkg::REG_GAIN_I_UP:          prdata = {16'd0, cfg_r.gain_i_up};
      lpp_pkg::REG_GAIN_P_DOWN:        prdata = {16'd0, cfg_r.gain_p_down};
      lpp_pkg::REG_GAIN_I_DOWN:        prdata = {16'd0, cfg_r.gain_i_down};
      lpp_pkg::REG_INTEGRAL_DECAY:     prdata = {16'd0, cfg_r.integral_decay};
      lpp_pkg::REG_INTEGRAL_THRESHOLD:
        prdata = {{8{cfg_r.integral_threshold[23]}}, cfg_r.integral_threshold};
      lpp_pkg::REG_TRAVEL_BOTTOM:
        prdata = {{8{cfg_r.travel_bottom[23]}}, cfg_r.travel_bottom};
      lpp_pkg::REG_TRAVEL_TOP:
        prdata = {{8{cfg_r.travel_top[23]}}, cfg_r.travel_top};
      default:                         prdata = '0;
    endcase
  end

endmodule

// ===== hdl/lpp_ctrl.sv =====
// ----------------------------------------------------------------------------
// lpp_ctrl
// Sequencer for one control tick: steps the shared multiplier and owns the
// channel handshakes.
// ----------------------------------------------------------------------------
module lpp_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output lpp_pkg::cmd_t cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PREP = 4'd1;
  localparam logic [3:0] S_MA   = 4'd2;
  localparam logic [3:0] S_MB   = 4'd3;
  localparam logic [3:0] S_DEC  = 4'd4;
  localparam logic [3:0] S_INT  = 4'd5;
  localparam logic [3:0] S_P1   = 4'd6;
  localparam logic [3:0] S_P2   = 4'd7;
  localparam logic [3:0] S_P3   = 4'd8;
  localparam logic [3:0] S_FIN  = 4'd9;

  logic [3:0] state_r;
  logic [3:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.mul_sel = lpp_pkg::MUL_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = S_MA;
      end
      S_MA: begin
        cmd.mul_sel = lpp_pkg::MUL_DEC_LO;
        state_nxt   = S_MB;
      end
      S_MB: begin
        cmd.acc_load = 1'b1;
        cmd.mul_sel  = lpp_pkg::MUL_DEC_HI;
        state_nxt    = S_DEC;
      end
      S_DEC: begin
        cmd.decay   = 1'b1;
        cmd.mul_sel = lpp_pkg::MUL_ERR_DT;
        state_nxt   = S_INT;
      end
      S_INT: begin
        cmd.integ   = 1'b1;
        cmd.mul_sel = lpp_pkg::MUL_ERR_GP;
        state_nxt   = S_P1;
      end
      S_P1: begin
        cmd.raw_clr = 1'b1;
        cmd.mul_sel = lpp_pkg::MUL_SUM_LO;
        state_nxt   = S_P2;
      end
      S_P2: begin
        cmd.raw_add = 1'b1;
        cmd.mul_sel = lpp_pkg::MUL_SUM_HI;
        state_nxt   = S_P3;
      end
      S_P3: begin
        cmd.raw_add   = 1'b1;
        cmd.raw_shift = 1'b1;
        state_nxt     = S_FIN;
      end
      S_FIN: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== hdl/lpp_dp.sv =====
// ----------------------------------------------------------------------------
// lpp_dp
// Datapath: target clamp, error, decaying integral, gain products through one
// shared 25x17 multiplier, and the power shaping into the output register.
// ----------------------------------------------------------------------------
module lpp_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  lpp_pkg::cfg_t       cfg,
  input  lpp_pkg::cmd_t       cmd,
  input  lpp_pkg::in_beat_t   in_beat,
  output lpp_pkg::out_beat_t  out_beat
);

  localparam logic signed [64:0] DB_POS  = 65'sd1310720;   // 20.0 in Q.16
  localparam logic signed [64:0] DB_NEG  = -65'sd1310720;
  localparam logic signed [64:0] SAT_POS = 65'sd6619136;   // 101.0 in Q.16
  localparam logic signed [64:0] SAT_NEG = -65'sd6619136;
  localparam logic signed [48:0] SUM_MAX = 49'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [7:0]  PW_MAX  = 8'sd100;
  localparam logic signed [7:0]  PW_MIN  = -8'sd100;

  lpp_pkg::in_beat_t  in_r;
  lpp_pkg::out_beat_t out_r;
  logic signed [23:0] tgt_r;
  logic signed [24:0] err_r;
  logic               le0_r;
  logic [47:0]        mag_r;
  logic               neg_r;
  logic signed [41:0] prod_r;
  logic [39:0]        acc_r;
  logic signed [48:0] dsum_r;
  logic signed [47:0] sum_r;
  logic signed [47:0] sum_nxt;
  logic               down_r;
  logic               down_nxt;
  logic signed [64:0] raw_r;

  logic signed [23:0] tgt_lo;
  logic signed [23:0] tgt_c;
  logic signed [24:0] mul_a;
  logic signed [16:0] mul_b;
  logic [15:0]        gp;
  logic [15:0]        gi;
  logic [63:0]        dec_total;
  logic [47:0]        dec_mag;
  logic signed [48:0] acc_sum;
  logic signed [64:0] prod_ext;
  logic signed [64:0] raw_sel;
  logic               in_db;
  logic               cut;
  logic [23:0]        neg_mag;
  logic signed [7:0]  pw;

  assign out_beat = out_r;

  // target clamp; bottom first so the top limit wins when they cross
  always_comb begin
    tgt_lo = (in_r.target < cfg.travel_bottom) ? cfg.travel_bottom : in_r.target;
    tgt_c  = (tgt_lo > cfg.travel_top) ? cfg.travel_top : tgt_lo;
  end

  assign gp = le0_r ? cfg.gain_p_down : cfg.gain_p_up;
  assign gi = le0_r ? cfg.gain_i_down : cfg.gain_i_up;

  always_comb begin
    case (cmd.mul_sel)
      lpp_pkg::MUL_DEC_LO: begin
        mul_a = $signed({1'b0, mag_r[23:0]});
        mul_b = $signed({1'b0, cfg.integral_decay});
      end
      lpp_pkg::MUL_DEC_HI: begin
        mul_a = $signed({1'b0, mag_r[47:24]});
        mul_b = $signed({1'b0, cfg.integral_decay});
      end
      lpp_pkg::MUL_ERR_DT: begin
        mul_a = err_r;
        mul_b = $signed({9'd0, in_r.elapsed_ms});
      end
      lpp_pkg::MUL_ERR_GP: begin
        mul_a = err_r;
        mul_b = $signed({1'b0, gp});
      end
      lpp_pkg::MUL_SUM_LO: begin
        mul_a = $signed({1'b0, sum_r[23:0]});
        mul_b = $signed({1'b0, gi});
      end
      lpp_pkg::MUL_SUM_HI: begin
        mul_a = $signed({sum_r[47], sum_r[47:24]});
        mul_b = $signed({1'b0, gi});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // decay: round half away from zero on the magnitude
  always_comb begin
    dec_total = {24'd0, acc_r} + {prod_r[39:0], 24'd0} + 64'd32768;
    dec_mag   = dec_total[63:16];
  end

  // error under threshold: add with 48-bit saturation, else decayed sum
  always_comb begin
    acc_sum  = dsum_r + 49'(prod_r);
    sum_nxt  = sum_r;
    down_nxt = down_r;
    if (!in_r.manual_mode) begin
      down_nxt = le0_r;
      if (err_r < 25'(cfg.integral_threshold)) begin
        if (acc_sum[48] != acc_sum[47]) begin
          sum_nxt = acc_sum[48] ? ~SUM_MAX[47:0] : SUM_MAX[47:0];
        end else begin
          sum_nxt = acc_sum[47:0];
        end
      end else begin
        sum_nxt = dsum_r[47:0];
      end
    end
  end

  always_comb begin
    prod_ext = 65'(prod_r);
    if (cmd.raw_shift) begin
      prod_ext = prod_ext <<< 24;
    end
  end

  // power shaping: deadband, freeze, limit cutoffs, saturation, truncation
  always_comb begin
    raw_sel = in_r.manual_mode ? 65'(signed'({in_r.manual_power, 16'd0})) : raw_r;
    in_db   = (raw_sel > DB_NEG) && (raw_sel < DB_POS);
    cut     = !in_r.encoder_reset &&
              (((!raw_sel[64] && (raw_sel != '0)) && (in_r.position > cfg.travel_top)) ||
               (raw_sel[64] && (in_r.position < cfg.travel_bottom)));
    neg_mag = 24'd0 - raw_sel[23:0];
    if (in_db || in_r.frozen || cut) begin
      pw = '0;
    end else if (raw_sel >= SAT_POS) begin
      pw = PW_MAX;
    end else if (raw_sel <= SAT_NEG) begin
      pw = PW_MIN;
    end else if (!raw_sel[64]) begin
      pw = $signed({1'b0, raw_sel[22:16]});
    end else begin
      pw = 8'sd0 - $signed({1'b0, neg_mag[22:16]});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      down_r <= 1'b0;
    end else if (cmd.integ) begin
      sum_r  <= sum_nxt;
      down_r <= down_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (cmd.load) begin
      in_r <= in_beat;
    end
    if (cmd.prep) begin
      tgt_r <= in_r.manual_mode ? in_r.position : tgt_c;
      err_r <= 25'(tgt_c) - 25'(in_r.position);
      le0_r <= !((25'(tgt_c) - 25'(in_r.position)) > 25'sd0);
      mag_r <= sum_r[47] ? 48'd0 - sum_r : sum_r;
      neg_r <= sum_r[47];
    end
    if (cmd.acc_load) begin
      acc_r <= prod_r[39:0];
    end
    if (cmd.decay) begin
      dsum_r <= neg_r ? 49'sd0 - $signed({1'b0, dec_mag}) : $signed({1'b0, dec_mag});
    end
    if (cmd.raw_clr) begin
      raw_r <= 65'(prod_r);
    end else if (cmd.raw_add) begin
      raw_r <= raw_r + prod_ext;
    end
    if (cmd.out_load) begin
      out_r.drive_power   <= pw;
      out_r.target_out    <= tgt_r;
      out_r.moving_down   <= down_r;
      out_r.reset_request <= in_r.encoder_reset;
    end
  end

endmodule

// ===== hdl/lift_position_pid_controller_core.sv =====
// ----------------------------------------------------------------------------
// lift_position_pid_controller_core
// Lift position PI controller with decaying integral, deadband, freeze and
// travel-limit cutoffs.
// ----------------------------------------------------------------------------
// Usage:
//   in_if  : one control tick per beat (position, target, elapsed time, flags).
//   out_if : one beat per tick (drive power, target, direction, reset request).
//   cfg_*  : APB write/read of the eight registers at byte address 4*index;
//            write only while the block is idle.
// Sequencing: the sequencer steps one 25x17 multiplier through six products
//   (decay low/high, error*time, error*gain, integral low/high); a new tick
//   is taken only once the previous one has been loaded into the output register.
// The output register holds a result while out_if.ready is low; the next tick
//   is accepted meanwhile and waits in its last step until the register frees.
// Reset: synchronous, active low; integral and direction flag clear, registers
//   return to their defaults, no beat is pending.
// ----------------------------------------------------------------------------
module lift_position_pid_controller_core (
  input  logic                       clk,
  input  logic                       rst_n,
  lpp_in_if.sink                     in_if,
  lpp_out_if.source                  out_if,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [lpp_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [lpp_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [lpp_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                       cfg_pready
);

  lpp_pkg::cfg_t      cfg;
  lpp_pkg::cmd_t      cmd;
  lpp_pkg::in_beat_t  in_beat;
  lpp_pkg::out_beat_t out_beat;

  assign cfg_pready = 1'b1;

  assign in_beat.position      = in_if.position;
  assign in_beat.target        = in_if.target;
  assign in_beat.elapsed_ms    = in_if.elapsed_ms;
  assign in_beat.manual_mode   = in_if.manual_mode;
  assign in_beat.manual_power  = in_if.manual_power;
  assign in_beat.frozen        = in_if.frozen;
  assign in_beat.encoder_reset = in_if.encoder_reset;

  assign out_if.drive_power   = out_beat.drive_power;
  assign out_if.target_out    = out_beat.target_out;
  assign out_if.moving_down   = out_beat.moving_down;
  assign out_if.reset_request = out_beat.reset_request;

  lpp_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  lpp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .cmd       (cmd)
  );

  lpp_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .cmd      (cmd),
    .in_beat  (in_beat),
    .out_beat (out_beat)
  );

endmodule
